FILE: design/pan_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pan_pkg;

  // configuration register file
  localparam int unsigned CFG_WIDTH  = 12;
  localparam int unsigned MASK_WIDTH = 3;
  localparam int unsigned ADDR_WIDTH = 2;
  localparam int unsigned NUM_AXES   = 3;

  // register indexes
  localparam logic [ADDR_WIDTH-1:0] REG_MIN_SPAN    = 2'd0;
  localparam logic [ADDR_WIDTH-1:0] REG_REST_FLOOR  = 2'd1;
  localparam logic [ADDR_WIDTH-1:0] REG_PRESS_DELTA = 2'd2;
  localparam logic [ADDR_WIDTH-1:0] REG_INVERT_MASK = 2'd3;

  // reset values
  localparam logic [CFG_WIDTH-1:0]  MIN_SPAN_RST    = 12'd200;
  localparam logic [CFG_WIDTH-1:0]  REST_FLOOR_RST  = 12'd2000;
  localparam logic [CFG_WIDTH-1:0]  PRESS_DELTA_RST = 12'd150;
  localparam logic [MASK_WIDTH-1:0] INVERT_MASK_RST = 3'd7;

  typedef struct packed {
    logic [CFG_WIDTH-1:0]  min_span;
    logic [CFG_WIDTH-1:0]  rest_floor;
    logic [CFG_WIDTH-1:0]  press_delta;
    logic [MASK_WIDTH-1:0] invert_mask;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/pan_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module pan_axis import pan_pkg::*; #(
  parameter int unsigned ADC_WIDTH = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 learn_i,
  input  wire logic [ADC_WIDTH-1:0] raw_i,
  input  wire cfg_t                 cfg_i,
  output logic                      ready_o,
  output logic [ADC_WIDTH-1:0]      low_o,
  output logic [ADC_WIDTH-1:0]      high_o
);

  // compare width covering both sample and register values plus a carry
  localparam int unsigned SW = ((ADC_WIDTH > CFG_WIDTH) ? ADC_WIDTH : CFG_WIDTH) + 1;

  logic                 armed_q, armed_d;
  logic                 seen_q, seen_d;
  logic [ADC_WIDTH-1:0] rest_q, rest_d;
  logic [ADC_WIDTH-1:0] low_q, low_d;
  logic [ADC_WIDTH-1:0] high_q, high_d;

  logic [SW-1:0]          raw_ext, rest_ext, low_ext, high_ext;
  logic [SW-1:0]          floor_ext, delta_ext, span_ext;
  logic [ADC_WIDTH+2:0]   avg_sum;

  assign raw_ext   = {{(SW-ADC_WIDTH){1'b0}}, raw_i};
  assign rest_ext  = {{(SW-ADC_WIDTH){1'b0}}, rest_q};
  assign low_ext   = {{(SW-ADC_WIDTH){1'b0}}, low_q};
  assign high_ext  = {{(SW-ADC_WIDTH){1'b0}}, high_q};
  assign floor_ext = {{(SW-CFG_WIDTH){1'b0}}, cfg_i.rest_floor};
  assign delta_ext = {{(SW-CFG_WIDTH){1'b0}}, cfg_i.press_delta};
  assign span_ext  = {{(SW-CFG_WIDTH){1'b0}}, cfg_i.min_span};

  // 7/8 running average of the rest level
  assign avg_sum = {rest_q, 3'b000} - {3'b000, rest_q} + {3'b000, raw_i};

  // learning step
  always_comb begin
    armed_d = armed_q;
    seen_d  = seen_q;
    rest_d  = rest_q;
    low_d   = low_q;
    high_d  = high_q;
    if (learn_i) begin
      if (armed_q) begin
        if (raw_i < low_q) low_d = raw_i;
        if (raw_i > high_q) high_d = raw_i;
      end else if (raw_ext < floor_ext) begin
        seen_d = 1'b0;
      end else if (!seen_q) begin
        rest_d = raw_i;
        seen_d = 1'b1;
      end else if (rest_ext < raw_ext + delta_ext) begin
        rest_d = avg_sum[ADC_WIDTH+2:3];
      end else begin
        low_d   = (rest_q < raw_i) ? rest_q : raw_i;
        high_d  = (rest_q > raw_i) ? rest_q : raw_i;
        armed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      seen_q  <= 1'b0;
      rest_q  <= '0;
      low_q   <= '0;
      high_q  <= '0;
    end else begin
      armed_q <= armed_d;
      seen_q  <= seen_d;
      rest_q  <= rest_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  // armed with enough span
  assign ready_o = armed_q && (high_ext > low_ext + span_ext);
  assign low_o   = low_q;
  assign high_o  = high_q;

endmodule

`default_nettype wire

FILE: design/pan_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pan_div #(
  parameter int unsigned ADC_WIDTH   = 12,
  parameter int unsigned LEVEL_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [ADC_WIDTH-1:0]   num_i,
  input  wire logic [ADC_WIDTH-1:0]   span_i,
  output logic                        busy_o,
  output logic [LEVEL_WIDTH-1:0]      quot_o
);

  localparam int unsigned DW    = ADC_WIDTH + LEVEL_WIDTH;
  localparam int unsigned CNT_W = $clog2(LEVEL_WIDTH + 1);

  logic                   busy_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [ADC_WIDTH-1:0]   rem_q, rem_d;
  logic [LEVEL_WIDTH-1:0] quo_q, quo_d;
  logic [ADC_WIDTH-1:0]   span_q;

  logic [DW-1:0]          dividend;
  logic [ADC_WIDTH:0]     partial;
  logic [ADC_WIDTH+1:0]   diff;
  logic                   ge;

  // num * (2^LEVEL_WIDTH - 1) as shift and subtract
  assign dividend = {num_i, {LEVEL_WIDTH{1'b0}}} - {{LEVEL_WIDTH{1'b0}}, num_i};

  // one restoring step per cycle
  assign partial = {rem_q, quo_q[LEVEL_WIDTH-1]};
  assign diff    = {1'b0, partial} - {2'b00, span_q};
  assign ge      = !diff[ADC_WIDTH+1];
  assign rem_d   = ge ? diff[ADC_WIDTH-1:0] : partial[ADC_WIDTH-1:0];
  assign quo_d   = {quo_q[LEVEL_WIDTH-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(LEVEL_WIDTH);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
    end
  end

  // upper dividend bits are already below the span, so only the low bits iterate
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend[DW-1:LEVEL_WIDTH];
      quo_q  <= dividend[LEVEL_WIDTH-1:0];
      span_q <= span_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

FILE: design/pedal_autocal_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-axis pedal auto-calibration and normalizer. Each transfer carries one
// filtered sample per axis; every axis first updates its calibration (rest
// tracking, arming on the first press, min/max growth) and then maps the same
// sample to a 0..2^LEVEL_WIDTH-1 fraction, with per-axis inversion and a 2%
// deadzone. The single shared divider produces one quotient bit per cycle
// and serves the three axes in turn, so an item's result is offered only
// after all three divisions. in_ready_o is high only while the block is
// idle; a finished result waits in the output register while the next input
// is taken. Calibration state clears on reset only; configuration writes
// take effect at once and belong in idle periods.
module pedal_autocal_normalizer import pan_pkg::*; #(
  parameter int unsigned ADC_WIDTH   = 12,
  parameter int unsigned LEVEL_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic [ADDR_WIDTH-1:0]  cfg_addr_i,
  input  wire logic [CFG_WIDTH-1:0]   cfg_data_i,
  // input channel
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [ADC_WIDTH-1:0]   throttle_raw_i,
  input  wire logic [ADC_WIDTH-1:0]   brake_raw_i,
  input  wire logic [ADC_WIDTH-1:0]   clutch_raw_i,
  // output channel
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [LEVEL_WIDTH-1:0]      throttle_level_o,
  output logic [LEVEL_WIDTH-1:0]      brake_level_o,
  output logic [LEVEL_WIDTH-1:0]      clutch_level_o,
  output logic                        all_calibrated_o
);

  localparam logic [LEVEL_WIDTH-1:0] DEADZONE =
    LEVEL_WIDTH'((((2 ** LEVEL_WIDTH) - 1) * 2 + 99) / 100);
  localparam logic [1:0] LAST_AXIS = 2'(NUM_AXES - 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LEARN = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  cfg_t       cfg_q;

  logic [ADC_WIDTH-1:0]   raw_q   [NUM_AXES];
  logic [LEVEL_WIDTH-1:0] level_q [NUM_AXES];

  logic                   ready_w [NUM_AXES];
  logic [ADC_WIDTH-1:0]   low_w   [NUM_AXES];
  logic [ADC_WIDTH-1:0]   high_w  [NUM_AXES];

  logic                   in_xfer, out_xfer, load_out;
  logic                   div_start, div_busy;
  logic [ADC_WIDTH-1:0]   div_num, div_span, sel_raw, sel_low, sel_high;
  logic [LEVEL_WIDTH-1:0] div_quot, lvl_inv, lvl_fin;

  logic                   out_valid_q;
  logic [LEVEL_WIDTH-1:0] throttle_q, brake_q, clutch_q;
  logic                   all_cal_q;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_span    <= MIN_SPAN_RST;
      cfg_q.rest_floor  <= REST_FLOOR_RST;
      cfg_q.press_delta <= PRESS_DELTA_RST;
      cfg_q.invert_mask <= INVERT_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MIN_SPAN:    cfg_q.min_span    <= cfg_data_i;
        REG_REST_FLOOR:  cfg_q.rest_floor  <= cfg_data_i;
        REG_PRESS_DELTA: cfg_q.press_delta <= cfg_data_i;
        REG_INVERT_MASK: cfg_q.invert_mask <= cfg_data_i[MASK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input sample capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      raw_q[0] <= throttle_raw_i;
      raw_q[1] <= brake_raw_i;
      raw_q[2] <= clutch_raw_i;
    end
  end

  // per-axis calibration state
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    pan_axis #(
      .ADC_WIDTH(ADC_WIDTH)
    ) u_axis (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .learn_i(state_q == ST_LEARN),
      .raw_i  (raw_q[a]),
      .cfg_i  (cfg_q),
      .ready_o(ready_w[a]),
      .low_o  (low_w[a]),
      .high_o (high_w[a])
    );
  end

  // operand select for the current axis
  assign sel_raw  = raw_q[axis_q];
  assign sel_low  = low_w[axis_q];
  assign sel_high = high_w[axis_q];
  assign div_num  = (sel_raw > sel_low) ? (sel_raw - sel_low) : '0;
  assign div_span = sel_high - sel_low;

  pan_div #(
    .ADC_WIDTH  (ADC_WIDTH),
    .LEVEL_WIDTH(LEVEL_WIDTH)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .span_i (div_span),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  // inversion, deadzone and readiness gate
  assign lvl_inv = cfg_q.invert_mask[axis_q] ? ~div_quot : div_quot;
  assign lvl_fin = (!ready_w[axis_q] || (lvl_inv < DEADZONE)) ? '0 : lvl_inv;

  // sequencer
  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LEARN;
      end
      ST_LEARN: begin
        axis_d  = '0;
        state_d = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (!div_busy) begin
          if (axis_q == LAST_AXIS) begin
            state_d = ST_DONE;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = ST_START;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  // per-axis level staging
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAIT && !div_busy) level_q[axis_q] <= lvl_fin;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      throttle_q <= level_q[0];
      brake_q    <= level_q[1];
      clutch_q   <= level_q[2];
      all_cal_q  <= ready_w[0] && ready_w[1] && ready_w[2];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign throttle_level_o = throttle_q;
  assign brake_level_o    = brake_q;
  assign clutch_level_o   = clutch_q;
  assign all_calibrated_o = all_cal_q;

endmodule

`default_nettype wire

FILE: design/pan_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pan_checker #(
  parameter int unsigned LEVEL_WIDTH = 16
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [LEVEL_WIDTH-1:0] throttle_level_o,
  input wire logic [LEVEL_WIDTH-1:0] brake_level_o,
  input wire logic [LEVEL_WIDTH-1:0] clutch_level_o,
  input wire logic                   all_calibrated_o
);

  localparam logic [LEVEL_WIDTH-1:0] DEADZONE =
    LEVEL_WIDTH'((((2 ** LEVEL_WIDTH) - 1) * 2 + 99) / 100);

  // one item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // after an output transfer a result is offered only if a new one was just loaded
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o || in_ready_o)
    else $error("result repeated after output transfer");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(throttle_level_o)
      && $stable(brake_level_o) && $stable(clutch_level_o) && $stable(all_calibrated_o))
    else $error("stalled result changed");

  // no level inside the deadzone
  a_deadzone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (throttle_level_o == '0 || throttle_level_o >= DEADZONE)
      && (brake_level_o == '0 || brake_level_o >= DEADZONE)
      && (clutch_level_o == '0 || clutch_level_o >= DEADZONE))
    else $error("level inside deadzone");

endmodule

bind pedal_autocal_normalizer pan_checker #(
  .LEVEL_WIDTH(LEVEL_WIDTH)
) u_pan_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .throttle_level_o(throttle_level_o),
  .brake_level_o   (brake_level_o),
  .clutch_level_o  (clutch_level_o),
  .all_calibrated_o(all_calibrated_o)
);

`default_nettype wire
